FILE: hdl/suie_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the set union / intersection engine.
// No dependencies.
package suie_pkg;

    localparam int SET_DEPTH = 32;
    localparam int SET_AW    = $clog2(SET_DEPTH);
    localparam int SET_SW    = $clog2(SET_DEPTH + 1);
    localparam int UNI_DEPTH = 2 * SET_DEPTH;
    localparam int UNI_AW    = $clog2(UNI_DEPTH);
    localparam int UNI_SW    = $clog2(UNI_DEPTH + 1);

    localparam int VAL_W  = 16;
    localparam int CNT_W  = 16;
    localparam int STAT_W = 2;
    localparam int CMD_W  = 3;

    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_A     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_B     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNION     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INTERSECT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_A_MINUS_B = 3'd5;
    localparam logic [CMD_W-1:0] CMD_B_MINUS_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NEITHER   = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage

FILE: hdl/suie_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module suie_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/set_union_intersection_engine_unit.sv
`timescale 1ns / 1ps
// Set union / intersection / difference engine, top level.
// Depends on suie_pkg and suie_ram.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser: cmd; tdata: value
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: value_res,count; tuser: status;
//                                                tlast: is_last
//  cfg       in   i_cfg_we                       i_cfg_wdata: class_size
//
// One command at a time. A query walks its source set and, for each element,
// scans the other set (or the union scratch memory) one compare per cycle.
// Reset empties both sets; set memory contents are not cleared. A stalled
// output holds the engine only when a new word must be emitted while the
// output register is still occupied.
module set_union_intersection_engine_unit
    import suie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,     // class_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] value
    input  logic [2:0]  s_axis_tuser,    // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [15:0] value_res, [31:16] count
    output logic [1:0]  m_axis_tuser,    // [1:0] status
    output logic        m_axis_tlast
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_SRC  = 3'd2;
    localparam logic [2:0] ST_CAP  = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_DEC  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_class;
    logic [SET_SW-1:0] r_size_a, r_size_b;
    logic [UNI_SW-1:0] r_usize;
    logic [CMD_W-1:0]  r_cmd;
    logic              r_src_b;
    logic [SET_SW-1:0] r_i;
    logic [UNI_SW-1:0] r_j;
    logic              r_rdv;
    logic              r_found;
    logic [VAL_W-1:0]  r_elem;
    logic [VAL_W-1:0]  r_hold;
    logic              r_hold_v;
    logic [STAT_W-1:0] r_pst;
    logic [SET_SW-1:0] r_cnt;

    logic              r_out_v;
    logic [VAL_W-1:0]  r_out_val;
    logic [CNT_W-1:0]  r_out_cnt;
    logic [STAT_W-1:0] r_out_st;
    logic              r_out_last;

    logic              in_acc;
    logic              out_free;
    logic              is_union;
    logic [SET_SW-1:0] ns;
    logic [UNI_SW-1:0] no;
    logic [VAL_W-1:0]  a_rd, b_rd, u_rd, src_rd, oth_rd;
    logic              a_we, b_we, u_we;
    logic [SET_AW-1:0] a_raddr, b_raddr;
    logic              keep;
    logic              want;
    logic              dec_stall;
    logic              last_src;
    logic [UNI_SW-1:0] used;
    logic [CNT_W-1:0]  cnt_val;
    logic              ld;
    logic [VAL_W-1:0]  ld_val;
    logic [CNT_W-1:0]  ld_cnt;
    logic [STAT_W-1:0] ld_st;
    logic              ld_last;
    logic [SET_SW-1:0] q_size;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_v || m_axis_tready;
    assign is_union      = (r_cmd == CMD_UNION);

    assign ns     = r_src_b ? r_size_b : r_size_a;
    assign no     = is_union ? r_usize
                  : (r_src_b ? UNI_SW'(r_size_a) : UNI_SW'(r_size_b));
    assign src_rd = r_src_b ? b_rd : a_rd;
    assign oth_rd = is_union ? u_rd : (r_src_b ? a_rd : b_rd);

    assign a_raddr = r_src_b ? r_j[SET_AW-1:0] : r_i[SET_AW-1:0];
    assign b_raddr = r_src_b ? r_i[SET_AW-1:0] : r_j[SET_AW-1:0];

    assign a_we = in_acc && (s_axis_tuser == CMD_ADD_A) && (r_size_a < SET_SW'(SET_DEPTH));
    assign b_we = in_acc && (s_axis_tuser == CMD_ADD_B) && (r_size_b < SET_SW'(SET_DEPTH));

    // keep on found for intersection and neither, on not-found otherwise
    assign want      = (r_cmd == CMD_INTERSECT) || (r_cmd == CMD_NEITHER);
    assign keep      = (r_found == want);
    assign dec_stall = keep && (r_cmd != CMD_NEITHER) && r_hold_v && !out_free;
    assign u_we      = (r_state == ST_DEC) && is_union && keep && !dec_stall;
    assign last_src  = (SET_SW'(r_i + 1'b1) >= ns);

    assign used    = UNI_SW'(r_size_a) + UNI_SW'(r_size_b) - UNI_SW'(r_cnt);
    assign cnt_val = (CNT_W'(used) >= r_class) ? '0 : r_class - CNT_W'(used);

    // size of the first source set of a query
    assign q_size = ((s_axis_tuser == CMD_UNION) || (s_axis_tuser == CMD_A_MINUS_B))
                  ? r_size_a : r_size_b;

    suie_ram #(.WIDTH(VAL_W), .DEPTH(SET_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_size_a[SET_AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rd)
    );

    suie_ram #(.WIDTH(VAL_W), .DEPTH(SET_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (r_size_b[SET_AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rd)
    );

    suie_ram #(.WIDTH(VAL_W), .DEPTH(UNI_DEPTH)) u_ram_u (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (r_usize[UNI_AW-1:0]),
        .i_wdata (r_elem),
        .i_raddr (r_j[UNI_AW-1:0]),
        .o_rdata (u_rd)
    );

    // output register load
    always_comb begin
        ld      = 1'b0;
        ld_val  = '0;
        ld_cnt  = '0;
        ld_st   = STAT_OK;
        ld_last = 1'b0;
        unique case (r_state)
            ST_PUSH: begin
                ld      = out_free;
                ld_val  = r_hold;
                ld_st   = r_pst;
                ld_last = 1'b1;
            end
            ST_DEC: begin
                ld     = keep && (r_cmd != CMD_NEITHER) && r_hold_v && out_free;
                ld_val = r_hold;
            end
            ST_FIN: begin
                ld      = out_free;
                ld_last = 1'b1;
                priority if (r_cmd == CMD_NEITHER) begin
                    ld_cnt = cnt_val;
                end else if (r_hold_v) begin
                    ld_val = r_hold;
                end else begin
                    ld_st = STAT_EMPTY;
                end
            end
            default: begin
                ld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ld) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
        if (ld) begin
            r_out_val  <= ld_val;
            r_out_cnt  <= ld_cnt;
            r_out_st   <= ld_st;
            r_out_last <= ld_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= '0;
        end else if (i_cfg_we) begin
            r_class <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_size_a <= '0;
            r_size_b <= '0;
            r_usize  <= '0;
            r_hold_v <= 1'b0;
            r_rdv    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cmd    <= s_axis_tuser;
                        r_hold   <= s_axis_tdata;
                        r_pst    <= STAT_OK;
                        r_hold_v <= 1'b0;
                        r_cnt    <= '0;
                        r_i      <= '0;
                        unique case (s_axis_tuser)
                            CMD_CLEAR: begin
                                r_size_a <= '0;
                                r_size_b <= '0;
                                r_usize  <= '0;
                                r_hold   <= '0;
                                r_state  <= ST_PUSH;
                            end
                            CMD_ADD_A: begin
                                if (a_we) begin
                                    r_size_a <= SET_SW'(r_size_a + 1'b1);
                                end else begin
                                    r_pst <= STAT_FULL;
                                end
                                r_state <= ST_PUSH;
                            end
                            CMD_ADD_B: begin
                                if (b_we) begin
                                    r_size_b <= SET_SW'(r_size_b + 1'b1);
                                end else begin
                                    r_pst <= STAT_FULL;
                                end
                                r_state <= ST_PUSH;
                            end
                            default: begin
                                r_usize <= '0;
                                // union with an empty A starts on B
                                r_src_b <= (s_axis_tuser != CMD_A_MINUS_B)
                                        && !((s_axis_tuser == CMD_UNION) && (r_size_a != '0));
                                if (s_axis_tuser == CMD_UNION) begin
                                    r_state <= ((r_size_a == '0) && (r_size_b == '0))
                                             ? ST_FIN : ST_SRC;
                                end else begin
                                    r_state <= (q_size == '0) ? ST_FIN : ST_SRC;
                                end
                            end
                        endcase
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SRC: begin
                    r_state <= ST_CAP;
                end
                ST_CAP: begin
                    r_elem  <= src_rd;
                    r_j     <= '0;
                    r_found <= 1'b0;
                    r_rdv   <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_rdv && (oth_rd == r_elem)) begin
                        r_found <= 1'b1;
                        r_rdv   <= 1'b0;
                        r_state <= ST_DEC;
                    end else if ((r_j == no) && !r_rdv) begin
                        r_state <= ST_DEC;
                    end else begin
                        r_rdv <= (r_j != no);
                        if (r_j != no) begin
                            r_j <= UNI_SW'(r_j + 1'b1);
                        end
                    end
                end
                ST_DEC: begin
                    if (!dec_stall) begin
                        if (keep) begin
                            if (r_cmd == CMD_NEITHER) begin
                                r_cnt <= SET_SW'(r_cnt + 1'b1);
                            end else begin
                                r_hold   <= r_elem;
                                r_hold_v <= 1'b1;
                            end
                            if (is_union) begin
                                r_usize <= UNI_SW'(r_usize + 1'b1);
                            end
                        end
                        priority if (!last_src) begin
                            r_i     <= SET_SW'(r_i + 1'b1);
                            r_state <= ST_SRC;
                        end else if (is_union && !r_src_b) begin
                            r_src_b <= 1'b1;
                            r_i     <= '0;
                            r_state <= (r_size_b == '0) ? ST_FIN : ST_SRC;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_cnt, r_out_val};
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tlast  = r_out_last;

    a_size_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size_a <= SET_SW'(SET_DEPTH)) && (r_size_b <= SET_SW'(SET_DEPTH)))
        else $error("set size beyond depth");

    a_union_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_usize <= UNI_SW'(r_size_a) + UNI_SW'(r_size_b)))
        else $error("union scratch larger than both sets");

    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt <= r_size_b))
        else $error("intersection count exceeds size of B");

    a_scan_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_j <= no))
        else $error("scan index past end of other set");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && !out_free |=> (r_state == ST_FIN))
        else $error("final word dropped while output stalled");

endmodule
